// ----- src/assert_macros.svh -----
// Assertion macros for the solver RTL.
// No dependencies; included by modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Check a property on every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Check a property on every clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

// ----- src/tsp_pkg.sv -----
// Types and constants of the Held-Karp tour solver.
// No dependencies.
`default_nettype none
package tsp_pkg;
   localparam int CITY_W  = 4;
   localparam int COUNT_W = 5;
   localparam int EDGE_W  = 16;
   localparam int TOTAL_W = 20;
   localparam logic [COUNT_W-1:0] COUNT_RESET = 5'd4;
   localparam logic [TOTAL_W-1:0] TOTAL_CAP = 20'hFFFFF;

   typedef struct packed {
      logic [CITY_W-1:0] from_city;
      logic [CITY_W-1:0] to_city;
      logic [EDGE_W-1:0] edge_cost;
      logic              last_entry;
   } req_word_type;

   typedef struct packed {
      logic [CITY_W-1:0]  tour_position;
      logic [CITY_W-1:0]  city;
      logic [TOTAL_W-1:0] route_cost;
      logic               last_of_tour;
   } rsp_word_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_INIT, ST_RELAX, ST_WRITE, ST_TOUR, ST_EMIT
   } solve_state_type;
endpackage
`default_nettype wire

// ----- src/tsp_if.sv -----
// Valid/ready channel interfaces for request and response words.
// Depends on tsp_pkg.
`default_nettype none
interface tsp_req_if;
   logic                 valid;
   logic                 ready;
   tsp_pkg::req_word_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface tsp_rsp_if;
   logic                 valid;
   logic                 ready;
   tsp_pkg::rsp_word_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- src/tsp_front.sv -----
// Front end: accepts request words into a two-entry queue.
// Depends on tsp_pkg and tsp_if.
`default_nettype none
module tsp_front (
   input  wire logic           clock,
   input  wire logic           reset,
   tsp_req_if.sink             req,
   output tsp_pkg::req_word_type q_data,
   output logic                q_valid,
   input  wire logic           q_pop
);
   import tsp_pkg::*;
   req_word_type      mem_ff [2];
   logic              wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0]        cnt_ff, cnt_in;
   logic              push;

   assign req.ready = (cnt_ff != 2'd2);
   assign push      = req.valid && req.ready;
   assign q_valid   = (cnt_ff != 2'd0);
   assign q_data    = mem_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff ^ push;
      rd_in  = rd_ff ^ (q_pop && q_valid);
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, q_pop && q_valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= 1'b0; rd_ff <= 1'b0; cnt_ff <= 2'd0;
      end else begin
         wr_ff <= wr_in; rd_ff <= rd_in; cnt_ff <= cnt_in;
      end
      if (push) mem_ff[wr_ff] <= req.data;
   end
endmodule
`default_nettype wire

// ----- src/tsp_back.sv -----
// Back end: cost matrix, bottom-up Held-Karp table, tour walk and emit.
// Depends on tsp_pkg, tsp_if and assert_macros.svh.
`default_nettype none
module tsp_back #(
   parameter int MAX_CITIES = 16,
   parameter int COST_BITS  = 16
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire tsp_pkg::req_word_type q_data,
   input  wire logic             q_valid,
   output logic                  q_pop,
   input  wire logic [tsp_pkg::COUNT_W-1:0] city_count,
   tsp_rsp_if.source             rsp
);
   import tsp_pkg::*;
   `include "assert_macros.svh"

   localparam int LIM   = (MAX_CITIES < 16) ? MAX_CITIES : 16;
   localparam int SB    = LIM - 1;             // set bits above city 0
   localparam int NSET  = 1 << SB;
   localparam int CW    = COST_BITS + 5;      // table entry width
   localparam int AW    = SB + 4;
   localparam logic [CW-1:0] INF = {CW{1'b1}};
   localparam logic [COST_BITS-1:0] CCAP = {COST_BITS{1'b1}};

   logic [COST_BITS-1:0] cm [256];
   logic [CW-1:0]        tbl [NSET*16];

   solve_state_type st_ff, st_in;
   logic [COUNT_W-1:0] n_ff, n_in;
   logic [SB:0]        set_ff, set_in;        // full visited set, bit 0 = city 0
   logic [3:0]         here_ff, here_in, nx_ff, nx_in, pick_ff, pick_in;
   logic [CW-1:0]      best_ff, best_in;
   logic [3:0]         k_ff, k_in;
   logic [CW-1:0]      total_ff, total_in;
   logic [3:0]         tour_ff [16];
   logic [3:0]         ek_ff, ek_in;
   logic               phase_ff, phase_in;   // 0: read issued, 1: data ready
   logic [COST_BITS-1:0] cm_q;
   logic [CW-1:0]      tb_q;
   logic [7:0]         cm_ra;
   logic [AW-1:0]      tb_ra, tb_wa;
   logic               tb_we, tour_we;
   logic [CW-1:0]      tb_wd, sum;
   logic [COST_BITS-1:0] ecost;
   logic [SB:0]        nset;
   logic               skip;

   assign nset = set_ff | (SB+1)'(1 << nx_ff);
   assign skip = set_ff[nx_ff];
   assign sum  = CW'(cm_q) + tb_q;

   assign ecost = (COST_BITS >= EDGE_W) ? COST_BITS'(q_data.edge_cost) :
                  ((q_data.edge_cost > EDGE_W'(CCAP)) ? CCAP : COST_BITS'(q_data.edge_cost));

   always_ff @(posedge clock) begin
      if (q_pop && ({4'd0, q_data.from_city} < MAX_CITIES)
          && ({4'd0, q_data.to_city} < MAX_CITIES))
         cm[{q_data.from_city, q_data.to_city}] <= ecost;
      cm_q <= cm[cm_ra];
      if (tb_we) tbl[tb_wa] <= tb_wd;
      tb_q <= tbl[tb_ra];
      if (tour_we) tour_ff[k_ff] <= pick_ff;
   end

   function automatic logic [SB:0] nset_pick(input logic [SB:0] s, input logic [3:0] p);
      nset_pick = s | (SB+1)'(1 << p);
   endfunction

   always_comb begin
      st_in = st_ff; n_in = n_ff; set_in = set_ff; here_in = here_ff; nx_in = nx_ff;
      pick_in = pick_ff; best_in = best_ff; k_in = k_ff; total_in = total_ff;
      ek_in = ek_ff; phase_in = phase_ff;
      q_pop = 1'b0; tb_we = 1'b0; tour_we = 1'b0; tb_wd = best_ff;
      tb_wa = {set_ff[SB:1], here_ff};
      cm_ra = {here_ff, nx_ff};
      tb_ra = {nset[SB:1], nx_ff};
      unique case (st_ff)
         ST_IDLE: begin
            q_pop = q_valid;
            if (q_valid && q_data.last_entry) begin
               // clamp city count and start at the full set
               if (city_count < 5'd2) n_in = 5'd2;
               else if (city_count > COUNT_W'(LIM)) n_in = COUNT_W'(LIM);
               else n_in = city_count;
               set_in = (SB+1)'(((1 << n_in) - 1));
               here_in = 4'd0; st_in = ST_INIT;
            end
         end
         ST_INIT: begin
            // full set: cost back home; read cm[here][0]
            cm_ra = {here_ff, 4'd0};
            if (!phase_ff) phase_in = 1'b1;
            else begin
               phase_in = 1'b0;
               tb_we = 1'b1; tb_wd = CW'(cm_q);
               if (5'(here_ff) + 5'd1 == n_ff) begin
                  set_in = set_ff - (SB+1)'(2); here_in = 4'd0;
                  nx_in = 4'd0; best_in = INF; st_in = ST_RELAX;
               end else here_in = here_ff + 4'd1;
            end
         end
         ST_RELAX: begin
            if (!set_ff[here_ff]) begin
               // city not in set: go to next
               if (5'(here_ff) + 5'd1 == n_ff) st_in = ST_WRITE;
               else here_in = here_ff + 4'd1;
            end else if (!phase_ff) begin
               if (skip) begin
                  if (5'(nx_ff) + 5'd1 == n_ff) st_in = ST_WRITE;
                  else nx_in = nx_ff + 4'd1;
               end else phase_in = 1'b1;
            end else begin
               phase_in = 1'b0;
               if (sum < best_ff) begin best_in = sum; pick_in = nx_ff; end
               if (5'(nx_ff) + 5'd1 == n_ff) st_in = ST_WRITE;
               else nx_in = nx_ff + 4'd1;
            end
         end
         ST_WRITE: begin
            // store best for (set, here) if here in set; then advance
            tb_we = set_ff[here_ff] && (k_ff == 4'd0) && !phase_ff;
            best_in = INF; nx_in = 4'd0;
            if (k_ff != 4'd0) begin
               // tour walk step
               tour_we = 1'b1;
               set_in = nset_pick(set_ff, pick_ff);
               here_in = pick_ff;
               if (5'(k_ff) + 5'd1 == n_ff) begin
                  ek_in = 4'd0; st_in = ST_EMIT;
               end else begin
                  k_in = k_ff + 4'd1; st_in = ST_RELAX;
               end
            end else if (phase_ff) begin
               // tour start: total from slot(1,0)
               phase_in = 1'b0;
               total_in = best_ff;
               k_in = 4'd1; pick_in = 4'd0; st_in = ST_RELAX;
               set_in = (SB+1)'(1); here_in = 4'd0;
            end else if (5'(here_ff) + 5'd1 == n_ff) begin
               here_in = 4'd0;
               if (set_ff == (SB+1)'(1)) st_in = ST_TOUR;
               else begin set_in = set_ff - (SB+1)'(2); st_in = ST_RELAX; end
            end else begin
               here_in = here_ff + 4'd1; st_in = ST_RELAX;
            end
         end
         ST_TOUR: begin
            // read slot(1,0) as total
            tb_ra = {(SB)'(0), 4'd0};
            if (!phase_ff) phase_in = 1'b1;
            else begin
               best_in = tb_q; st_in = ST_WRITE; phase_in = 1'b1;
               tb_wa = {set_ff[SB:1], here_ff};
            end
         end
         ST_EMIT: begin
            if (rsp.ready) begin
               if (5'(ek_ff) + 5'd1 == n_ff) begin
                  st_in = ST_IDLE; k_in = 4'd0;
               end else ek_in = ek_ff + 4'd1;
            end
         end
         default: st_in = ST_IDLE;
      endcase
   end

   // ST_TOUR exits with phase set so WRITE takes the total branch; that branch must
   // not store, hence the write-enable gating on !phase_ff.
   assign rsp.valid = (st_ff == ST_EMIT);
   always_comb begin
      rsp.data.tour_position = ek_ff;
      rsp.data.city          = (ek_ff == 4'd0) ? 4'd0 : tour_ff[ek_ff];
      rsp.data.route_cost    = (total_ff > CW'(TOTAL_CAP)) ? TOTAL_CAP
                                                          : TOTAL_W'(total_ff);
      rsp.data.last_of_tour  = (5'(ek_ff) + 5'd1 == n_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE; k_ff <= 4'd0; phase_ff <= 1'b0; ek_ff <= 4'd0;
      end else begin
         st_ff <= st_in; k_ff <= k_in; phase_ff <= phase_in; ek_ff <= ek_in;
      end
      n_ff <= n_in; set_ff <= set_in; here_ff <= here_in; nx_ff <= nx_in;
      pick_ff <= pick_in; best_ff <= best_in; total_ff <= total_in;
   end

   `ASSERT_CLK(a_pop_idle, clock, reset, q_pop |-> (st_ff == ST_IDLE), "pop outside idle")
   `ASSERT_CLK(a_emit_hold, clock, reset,
      (rsp.valid && !rsp.ready) |=> (rsp.valid && $stable(ek_ff)), "emit moved while stalled")
   `ASSERT_ALWAYS(a_reset_idle, clock, $past(reset) |-> (st_ff == ST_IDLE), "not idle after reset")
endmodule
`default_nettype wire

// ----- src/tsp_bitmask_dp_solver_top.sv -----
// Held-Karp tour solver top. An accepted request word is held in a two-entry queue,
// then written to the cost matrix when popped; words flow one per cycle through the queue
// while the solver idles. The last word starts a solve: setup, the bottom-up table fill,
// then the tour walk; then N response words, one per cycle while rsp ready stays high.
// One solve at a time.
// Reset (synchronous, active high) clears control and city_count to 4, not the memories.
`default_nettype none
module tsp_bitmask_dp_solver_top #(
   parameter int MAX_CITIES = 16,
   parameter int COST_BITS  = 16
) (
   input  wire logic clock,
   input  wire logic reset,
   tsp_req_if.sink   req_chan,
   tsp_rsp_if.source rsp_chan,
   input  wire logic csr_we,
   input  wire logic [tsp_pkg::COUNT_W-1:0] csr_wdata
);
   import tsp_pkg::*;
   req_word_type      q_data;
   logic              q_valid, q_pop;
   logic [COUNT_W-1:0] count_ff;

   // hold city count register
   always_ff @(posedge clock) begin
      if (reset) count_ff <= COUNT_RESET;
      else if (csr_we) count_ff <= csr_wdata;
   end

   tsp_front u_front (
      .clock, .reset, .req(req_chan), .q_data, .q_valid, .q_pop
   );

   tsp_back #(.MAX_CITIES(MAX_CITIES), .COST_BITS(COST_BITS)) u_back (
      .clock, .reset, .q_data, .q_valid, .q_pop, .city_count(count_ff), .rsp(rsp_chan)
   );
endmodule
`default_nettype wire

// ----- sim/tb.sv -----
// Testbench for tsp_bitmask_dp_solver_top: loads cost matrices, triggers solves
// and checks every tour word against an in-bench Held-Karp predictor.
// Depends on tsp_pkg, tsp_if and the solver top level.
`default_nettype none
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import tsp_pkg::*;

   localparam int NCITY       = 16;
   localparam int IDLE_LIMIT  = 200000;  // cycles without any handshake
   localparam int SETTLE      = 20;      // quiet cycles after the last tour word
   localparam int ITEM_TARGET = 140;

   // Scoreboard: shadow of the cost matrix and the city count, plus the tours
   // still owed by the block.
   class tour_scoreboard;
      logic [EDGE_W-1:0] costs [NCITY][NCITY];
      logic [COUNT_W-1:0] count = COUNT_RESET;
      longint completion [];
      rsp_word_type owed [$];
      int errors = 0;
      int tours = 0;

      task report(input string msg);
         $display("MISMATCH: %s", msg);
         errors++;
      endtask

      function void set_count(input logic [COUNT_W-1:0] v);
         count = v;
      endfunction

      function longint cheapest_step(input int set, input int here, input int n,
                                     output int pick);
         longint best;
         longint c;
         best = -1;
         pick = 0;
         for (int nx = 0; nx < n; nx++) begin
            if (set[nx]) continue;
            c = longint'(costs[here][nx])
                + completion[((set | (1 << nx)) >> 1) * NCITY + nx];
            if (best < 0 || c < best) begin
               best = c;
               pick = nx;
            end
         end
         return best;
      endfunction

      // Fill the completion table bottom-up, then walk the cheapest tour.
      function void predict_tour();
         int n;
         int full;
         int pick;
         int here;
         int visited;
         longint total;
         int route [NCITY];
         rsp_word_type w;
         n = (count < 2) ? 2 : ((count > NCITY) ? NCITY : int'(count));
         completion = new[(1 << (n - 1)) * NCITY];
         full = (1 << n) - 1;
         for (int set = full; set >= 1; set -= 2)
            for (int h = 0; h < n; h++) begin
               if (!set[h]) continue;
               if (set == full)
                  completion[(set >> 1) * NCITY + h] = longint'(costs[h][0]);
               else completion[(set >> 1) * NCITY + h] = cheapest_step(set, h, n, pick);
            end
         total = completion[h_slot0()];
         if (total > TOTAL_CAP) total = TOTAL_CAP;
         visited = 1;
         here = 0;
         route[0] = 0;
         for (int k = 1; k < n; k++) begin
            void'(cheapest_step(visited, here, n, pick));
            route[k] = pick;
            visited |= 1 << pick;
            here = pick;
         end
         for (int k = 0; k < n; k++) begin
            w.tour_position = k[CITY_W-1:0];
            w.city          = route[k][CITY_W-1:0];
            w.route_cost    = total[TOTAL_W-1:0];
            w.last_of_tour  = (k == n - 1);
            owed.push_back(w);
         end
         tours++;
      endfunction

      function int h_slot0();
         return 0;
      endfunction

      function void note_request(input req_word_type w);
         costs[w.from_city][w.to_city] = w.edge_cost;
         if (w.last_entry) predict_tour();
      endfunction

      task check_result(input rsp_word_type got);
         rsp_word_type exp_w;
         if (owed.size() == 0) begin
            report($sformatf("unexpected tour word pos=%0d city=%0d",
                             got.tour_position, got.city));
            return;
         end
         exp_w = owed.pop_front();
         if (got.tour_position !== exp_w.tour_position)
            report($sformatf("tour_position %0d, want %0d",
                             got.tour_position, exp_w.tour_position));
         if (got.city !== exp_w.city)
            report($sformatf("city %0d, want %0d at pos %0d",
                             got.city, exp_w.city, exp_w.tour_position));
         if (got.route_cost !== exp_w.route_cost)
            report($sformatf("route_cost %0d, want %0d",
                             got.route_cost, exp_w.route_cost));
         if (got.last_of_tour !== exp_w.last_of_tour)
            report($sformatf("last_of_tour %0b, want %0b at pos %0d",
                             got.last_of_tour, exp_w.last_of_tour, exp_w.tour_position));
      endtask
   endclass

   logic clock;
   logic reset;
   logic csr_we;
   logic [COUNT_W-1:0] csr_wdata;

   tsp_req_if req_chan ();
   tsp_rsp_if rsp_chan ();

   tsp_bitmask_dp_solver_top i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_we   (csr_we),
      .csr_wdata(csr_wdata)
   );

   tour_scoreboard sb = new();
   bit written [NCITY][NCITY];   // matrix entries loaded since reset
   bit calm = 0;                 // set for the closing stretch: no idling at all
   int words_sent = 0;
   int quiet_cycles = 0;
   int rsp_stall = 0;

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   // Drive ready with random stall bursts; hold it high once the run is calm.
   always @(negedge clock) begin
      if (reset || calm) begin
         rsp_chan.ready = 1'b1;
      end else if (rsp_stall > 0) begin
         rsp_chan.ready = 1'b0;
         rsp_stall--;
      end else if ($urandom_range(0, 5) == 0) begin
         rsp_chan.ready = 1'b0;
         rsp_stall = $urandom_range(0, 7);
      end else begin
         rsp_chan.ready = 1'b1;
      end
   end

   // Monitor both channels at the rising edge; the watchdog counts dead cycles.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_chan.valid && req_chan.ready) sb.note_request(req_chan.data);
         if (rsp_chan.valid && rsp_chan.ready) sb.check_result(rsp_chan.data);
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no word moved for %0d cycles", IDLE_LIMIT);
            $display("tsp_bitmask_dp_solver_top test failed");
            $finish;
         end
      end
   end

   // Send one request word; hold valid until the block takes it.
   task send_word(input req_word_type w);
      int gap;
      @(negedge clock);
      if (!calm && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 8);
         req_chan.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid = 1'b1;
      req_chan.data  = w;
      do @(posedge clock); while (!req_chan.ready);
      written[w.from_city][w.to_city] = 1'b1;
      words_sent++;
   endtask

   // Write the city count; only called while the block is idle.
   task write_count(input logic [COUNT_W-1:0] v);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_wdata = v;
      @(negedge clock);
      csr_we = 1'b0;
      sb.set_count(v);
   endtask

   // Wait until every owed tour word arrived, then let the block settle.
   task drain();
      @(negedge clock);
      req_chan.valid = 1'b0;
      while (sb.owed.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // mode 0: costs 0/1 (ties), mode 1: extremes and full range, mode 2: small
   function logic [EDGE_W-1:0] pick_cost(input int mode);
      case (mode)
         0: return EDGE_W'($urandom_range(0, 1));
         1: begin
            case ($urandom_range(0, 3))
               0: return '0;
               1: return '1;
               default: return EDGE_W'($urandom_range(0, 65535));
            endcase
         end
         default: return EDGE_W'($urandom_range(0, 15));
      endcase
   endfunction

   // One problem: optional count write, fill missing entries (or all, on reload) of the n x n
   // matrix, scatter extra writes (some outside the active cities), then the
   // last word triggers the solve.
   task run_problem(input int cfg, input int n, input int extra, input int mode,
                    input bit reload);
      req_word_type w;
      if (cfg >= 0) write_count(cfg[COUNT_W-1:0]);
      for (int r = 0; r < n; r++)
         for (int c = 0; c < n; c++)
            if (reload || !written[r][c]) begin
               w.from_city  = r[CITY_W-1:0];
               w.to_city    = c[CITY_W-1:0];
               w.edge_cost  = pick_cost(mode);
               w.last_entry = 1'b0;
               send_word(w);
            end
      for (int i = 0; i < extra; i++) begin
         if ($urandom_range(0, 3) == 0) begin
            w.from_city = CITY_W'($urandom_range(0, NCITY - 1));
            w.to_city   = CITY_W'($urandom_range(0, NCITY - 1));
         end else begin
            w.from_city = CITY_W'($urandom_range(0, n - 1));
            w.to_city   = CITY_W'($urandom_range(0, n - 1));
         end
         w.edge_cost  = pick_cost(mode);
         w.last_entry = 1'b0;
         send_word(w);
      end
      w.from_city  = CITY_W'($urandom_range(0, n - 1));
      w.to_city    = CITY_W'($urandom_range(0, n - 1));
      w.edge_cost  = pick_cost(mode);
      w.last_entry = 1'b1;
      send_word(w);
      drain();
   endtask

   initial begin
      int n;
      int cfg;
      reset          = 1'b1;
      csr_we         = 1'b0;
      csr_wdata      = '0;
      req_chan.valid = 1'b0;
      req_chan.data  = '0;
      rsp_chan.ready = 1'b1;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: reset count of four with tie-heavy costs, then two cities
      // with extreme costs, then counts of one and zero, below the legal range.
      run_problem(-1, 4, 0, 0, 1'b1);
      run_problem(2, 2, 0, 1, 1'b1);
      run_problem(1, 2, 0, 1, 1'b0);
      run_problem(0, 2, 0, 2, 1'b0);

      // Upper extremes of the register: written, then replaced before a solve
      // since a sixteen-city solve is far too long for this run.
      write_count(5'd31);
      write_count(5'd16);

      // Random problems of two to seven cities.
      while (words_sent < ITEM_TARGET) begin
         if (words_sent > ITEM_TARGET - 30) calm = 1;
         n   = $urandom_range(2, 7);
         cfg = ($urandom_range(0, 7) == 0 && n == 2) ? 0 : n;
         run_problem(cfg, n, $urandom_range(0, 6), $urandom_range(0, 2),
                     $urandom_range(0, 5) == 0);
      end

      $display("covered %0d request words and %0d tours, city counts 0..7 plus 16/31 writes",
               words_sent, sb.tours);
      if (sb.errors == 0 && sb.owed.size() == 0) begin
         $display("tsp_bitmask_dp_solver_top test passed");
      end else begin
         $display("%0d mismatches, %0d tour words still owed", sb.errors, sb.owed.size());
         $display("tsp_bitmask_dp_solver_top test failed");
      end
      $finish;
   end
endmodule
`default_nettype wire
